// ===== rtl/bst_pkg.sv =====
// Shared types and constants for the BASIC statement tokenizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bst_pkg;

  localparam int TEXT_CAPACITY_DEF = 256;
  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;

  // Token kinds as seen on the result channel.
  localparam logic [3:0] K_EOF   = 4'd0;
  localparam logic [3:0] K_NUM   = 4'd1;
  localparam logic [3:0] K_NAME  = 4'd2;
  localparam logic [3:0] K_STR   = 4'd3;
  localparam logic [3:0] K_OP    = 4'd4;
  localparam logic [3:0] K_COMMA = 4'd5;
  localparam logic [3:0] K_SEMI  = 4'd6;
  localparam logic [3:0] K_LP    = 4'd7;
  localparam logic [3:0] K_RP    = 4'd8;

  // Operator codes for the two-character comparisons.
  localparam logic [7:0] OP_LE = 8'h6C; // l
  localparam logic [7:0] OP_GE = 8'h67; // g
  localparam logic [7:0] OP_NE = 8'h6E; // n

  // Keyword operators, as the first three stored bytes of a name.
  localparam logic [23:0] KW_AND = "AND";
  localparam logic [23:0] KW_XOR = "XOR";
  localparam logic [23:0] KW_NOT = "NOT";
  localparam logic [23:0] KW_MOD = "MOD";
  localparam logic [23:0] KW_OR  = {8'h00, "OR"};

  // One result beat, without its last flag.
  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  op_code;
    logic [7:0]  text_byte;
    logic        byte_valid;
    logic        token_done;
    logic [15:0] token_start;
    logic [7:0]  text_length;
  } res_t;

  // One queue entry: the one or two results caused by a character.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } ent_t;

  function automatic res_t mk_res(logic [3:0] kind, logic [7:0] op, logic [7:0] byte_v,
                                  logic valid, logic done, logic [15:0] start,
                                  logic [7:0] len);
    res_t r;
    r.token_kind  = kind;
    r.op_code     = op;
    r.text_byte   = byte_v;
    r.byte_valid  = valid;
    r.token_done  = done;
    r.token_start = start;
    r.text_length = len;
    return r;
  endfunction

  function automatic logic [7:0] upc(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    logic [7:0] u;
    u = upc(c);
    return (u >= "A" && u <= "Z") || c == "_";
  endfunction

endpackage

// ===== rtl/bst_front.sv =====
// Front end of the tokenizer: lexer state and the per-character decision.
// Depends on bst_pkg; feeds bst_queue with one entry per character that causes results.
`timescale 1ns / 1ps

module bst_front import bst_pkg::*; #(
  parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic       req_type,
  input  logic [7:0] char_in,
  output logic       has_res,
  output ent_t       entry
);

  localparam int CNT_W = $clog2(TEXT_CAPACITY);
  localparam logic [CNT_W-1:0] NUM_LIMIT = CNT_W'(TEXT_CAPACITY - 2);
  localparam logic [CNT_W-1:0] STR_LIMIT = CNT_W'(TEXT_CAPACITY - 1);

  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_NUM  = 4'd1;
  localparam logic [3:0] M_NAME = 4'd2;
  localparam logic [3:0] M_STR  = 4'd3;
  localparam logic [3:0] M_STRQ = 4'd4;
  localparam logic [3:0] M_AMP  = 4'd5;
  localparam logic [3:0] M_LT   = 4'd6;
  localparam logic [3:0] M_GT   = 4'd7;
  localparam logic [3:0] M_BSL  = 4'd8;

  logic [3:0]               mode_r, mode_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [7:0]               lastc_r, lastc_nxt;
  logic [23:0]              pref_r, pref_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;

  logic [7:0]  c, u;
  logic [15:0] start16, pos16;
  logic [7:0]  cnt8, cnt_inc8;
  logic [CNT_W-1:0] cnt_inc;
  logic [23:0] pref_st;
  logic        kw;
  logic        fin_has, beg_has, beg_store, is_space;
  res_t        fin_res, beg_res, slot0, slot1;
  logic [3:0]  beg_mode;
  logic [7:0]  beg_ch;
  logic [1:0]  nres;
  logic        num_ok, name_ok, fall_back;

  assign c        = char_in;
  assign u        = upc(char_in);
  assign start16  = 16'(start_r);
  assign pos16    = 16'(pos_r);
  assign cnt8     = 8'(cnt_r);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cnt_inc8 = 8'(cnt_inc);
  assign pref_st  = (cnt_r < CNT_W'(3)) ? {pref_r[15:0], c} : pref_r;
  assign is_space = (c == " ") || (c == 8'h09);

  assign num_ok = is_digit(u) || u == "." || (u >= "A" && u <= "F") || u == "H" ||
                  ((u == "+" || u == "-") && (lastc_r == "E" || lastc_r == "D"));
  assign name_ok = is_alpha(c) || is_digit(c) || c == "$" || c == "%" || c == "&" ||
                   c == "!" || c == "#";

  // Closing result of whatever token is open.
  always_comb begin
    kw = (cnt_r == CNT_W'(3) && (pref_r == KW_AND || pref_r == KW_XOR ||
                                 pref_r == KW_NOT || pref_r == KW_MOD)) ||
         (cnt_r == CNT_W'(2) && pref_r == KW_OR);
    fin_has = 1'b1;
    fin_res = '0;
    unique case (mode_r)
      M_NUM: fin_res = mk_res(K_NUM, 8'h00, 8'h00, 1'b0, 1'b1, start16, cnt8);
      M_NAME: begin
        if (kw) begin
          fin_res = mk_res(K_OP, (cnt_r == CNT_W'(3)) ? pref_r[23:16] : pref_r[15:8],
                           8'h00, 1'b0, 1'b1, start16, cnt8);
        end else begin
          fin_res = mk_res(K_NAME, 8'h00, 8'h00, 1'b0, 1'b1, start16, cnt8);
        end
      end
      M_STR, M_STRQ: fin_res = mk_res(K_STR, 8'h00, 8'h00, 1'b0, 1'b1, start16, cnt8);
      M_AMP: fin_res = mk_res(K_OP, "&", 8'h00, 1'b0, 1'b1, start16, 8'h00);
      M_LT:  fin_res = mk_res(K_OP, "<", 8'h00, 1'b0, 1'b1, start16, 8'h00);
      M_GT:  fin_res = mk_res(K_OP, ">", 8'h00, 1'b0, 1'b1, start16, 8'h00);
      M_BSL: fin_res = mk_res(K_OP, 8'h5C, 8'h00, 1'b0, 1'b1, start16, 8'h00);
      default: fin_has = 1'b0;
    endcase
  end

  // Opening of a new token by the current character.
  always_comb begin
    beg_has   = 1'b0;
    beg_store = 1'b0;
    beg_mode  = M_IDLE;
    beg_ch    = u;
    beg_res   = '0;
    priority if (is_space) begin
      beg_mode = M_IDLE;
    end else if (is_digit(c) || c == ".") begin
      beg_mode  = M_NUM;
      beg_store = 1'b1;
      beg_has   = 1'b1;
      beg_res   = mk_res(K_NUM, 8'h00, u, 1'b1, 1'b0, pos16, 8'd1);
    end else if (c == "&") begin
      beg_mode = M_AMP;
    end else if (is_alpha(c)) begin
      beg_mode  = M_NAME;
      beg_store = 1'b1;
      beg_has   = 1'b1;
      beg_res   = mk_res(K_NAME, 8'h00, u, 1'b1, 1'b0, pos16, 8'd1);
    end else if (c == 8'h22) begin
      beg_mode = M_STR;
    end else if (c == ",") begin
      beg_has = 1'b1;
      beg_res = mk_res(K_COMMA, 8'h00, 8'h00, 1'b0, 1'b1, pos16, 8'h00);
    end else if (c == ";") begin
      beg_has = 1'b1;
      beg_res = mk_res(K_SEMI, 8'h00, 8'h00, 1'b0, 1'b1, pos16, 8'h00);
    end else if (c == "(") begin
      beg_has = 1'b1;
      beg_res = mk_res(K_LP, 8'h00, 8'h00, 1'b0, 1'b1, pos16, 8'h00);
    end else if (c == ")") begin
      beg_has = 1'b1;
      beg_res = mk_res(K_RP, 8'h00, 8'h00, 1'b0, 1'b1, pos16, 8'h00);
    end else if (c == "<") begin
      beg_mode = M_LT;
    end else if (c == ">") begin
      beg_mode = M_GT;
    end else if (c == 8'h5C) begin
      beg_mode = M_BSL;
    end else begin
      beg_has = 1'b1;
      beg_res = mk_res(K_OP, c, 8'h00, 1'b0, 1'b1, pos16, 8'h00);
    end
  end

  // Per-character decision; fall_back means close the open token and reopen.
  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    lastc_nxt = lastc_r;
    pref_nxt  = pref_r;
    pos_nxt   = pos_r + POSITION_BITS'(1);
    start_nxt = start_r;
    slot0     = '0;
    slot1     = '0;
    nres      = 2'd0;
    fall_back = 1'b0;

    if (req_type) begin
      if (fin_has) begin
        slot0 = fin_res;
        slot1 = mk_res(K_EOF, 8'h00, 8'h00, 1'b0, 1'b1, pos16, 8'h00);
        nres  = 2'd2;
      end else begin
        slot0 = mk_res(K_EOF, 8'h00, 8'h00, 1'b0, 1'b1, pos16, 8'h00);
        nres  = 2'd1;
      end
      mode_nxt  = M_IDLE;
      cnt_nxt   = '0;
      lastc_nxt = 8'h00;
      pref_nxt  = 24'h0;
      pos_nxt   = '0;
      start_nxt = '0;
    end else begin
      unique case (mode_r)
        M_NUM, M_NAME: begin
          if ((mode_r == M_NUM) ? num_ok : name_ok) begin
            if (cnt_r < NUM_LIMIT) begin
              slot0 = mk_res((mode_r == M_NUM) ? K_NUM : K_NAME, 8'h00, u, 1'b1, 1'b0,
                             start16, cnt_inc8);
              nres      = 2'd1;
              cnt_nxt   = cnt_inc;
              lastc_nxt = u;
              pref_nxt  = (cnt_r < CNT_W'(3)) ? {pref_r[15:0], u} : pref_r;
            end
          end else begin
            fall_back = 1'b1;
          end
        end
        M_STR, M_STRQ: begin
          if (mode_r == M_STR && c == 8'h22) begin
            mode_nxt = M_STRQ;
          end else if (mode_r == M_STRQ && c != 8'h22) begin
            fall_back = 1'b1;
          end else begin
            mode_nxt = M_STR;
            if (cnt_r < STR_LIMIT) begin
              slot0     = mk_res(K_STR, 8'h00, c, 1'b1, 1'b0, start16, cnt_inc8);
              nres      = 2'd1;
              cnt_nxt   = cnt_inc;
              lastc_nxt = c;
              pref_nxt  = pref_st;
            end
          end
        end
        M_AMP: begin
          if (u == "H") begin
            slot0     = mk_res(K_NUM, 8'h00, "&", 1'b1, 1'b0, start16, 8'd1);
            slot1     = mk_res(K_NUM, 8'h00, "H", 1'b1, 1'b0, start16, 8'd2);
            nres      = 2'd2;
            mode_nxt  = M_NUM;
            cnt_nxt   = CNT_W'(2);
            lastc_nxt = "H";
            pref_nxt  = {8'h00, "&H"};
          end else begin
            fall_back = 1'b1;
          end
        end
        M_LT, M_GT, M_BSL: begin
          if (mode_r == M_LT && c == "=") begin
            slot0 = mk_res(K_OP, OP_LE, 8'h00, 1'b0, 1'b1, start16, 8'h00);
          end else if (mode_r == M_LT && c == ">") begin
            slot0 = mk_res(K_OP, OP_NE, 8'h00, 1'b0, 1'b1, start16, 8'h00);
          end else if (mode_r == M_GT && c == "=") begin
            slot0 = mk_res(K_OP, OP_GE, 8'h00, 1'b0, 1'b1, start16, 8'h00);
          end else if (mode_r == M_BSL && c == 8'h5C) begin
            slot0 = mk_res(K_OP, 8'h5C, 8'h00, 1'b0, 1'b1, start16, 8'h00);
          end else begin
            fall_back = 1'b1;
          end
          if (!fall_back) begin
            nres     = 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        default: fall_back = 1'b1;
      endcase

      if (fall_back) begin
        if (fin_has) begin
          slot0 = fin_res;
          slot1 = beg_res;
        end else begin
          slot0 = beg_res;
        end
        nres     = {1'b0, fin_has} + {1'b0, beg_has};
        mode_nxt = beg_mode;
        if (!is_space) begin
          start_nxt = pos_r;
          cnt_nxt   = beg_store ? CNT_W'(1) : '0;
          lastc_nxt = beg_store ? beg_ch : 8'h00;
          pref_nxt  = beg_store ? {16'h0, beg_ch} : 24'h0;
        end
      end
    end
  end

  assign has_res     = nres != 2'd0;
  assign entry.two   = nres == 2'd2;
  assign entry.r0    = slot0;
  assign entry.r1    = slot1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      cnt_r   <= '0;
      lastc_r <= 8'h00;
      pref_r  <= 24'h0;
      pos_r   <= '0;
      start_r <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      lastc_r <= lastc_nxt;
      pref_r  <= pref_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ===== rtl/bst_queue.sv =====
// Short queue of result entries between the front and back ends.
// Depends on bst_pkg for the entry type and depth.
`timescale 1ns / 1ps

module bst_queue import bst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ent_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output ent_t rdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  ent_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;

  assign full  = cnt_r == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

// ===== rtl/bst_back.sv =====
// Back end of the tokenizer: splits queue entries into single result beats.
// Depends on bst_pkg; drains bst_queue into the output register.
`timescale 1ns / 1ps

module bst_back import bst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  ent_t q_head,
  output logic q_pop,
  input  logic out_ready,
  output logic out_valid,
  output res_t out_res,
  output logic out_last
);

  logic valid_r, valid_nxt;
  logic half_r, half_nxt;
  res_t res_r;
  logic last_r;
  logic load;

  assign load = (!valid_r || out_ready) && !q_empty;
  assign q_pop = load && (!q_head.two || half_r);

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    if (!valid_r || out_ready) begin
      valid_nxt = !q_empty;
    end
    if (load) begin
      half_nxt = q_head.two && !half_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= half_r ? q_head.r1 : q_head.r0;
      last_r <= !q_head.two || half_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/basic_statement_tokenizer.sv =====
// Top level of the BASIC statement tokenizer.
// Depends on bst_pkg, bst_front, bst_queue and bst_back.
`timescale 1ns / 1ps

// The tokenizer takes a BASIC statement one character per input beat and an
// end-of-statement beat (in_req_type high) after the last character. It
// returns a stream of result beats: each stored text byte of a number, name
// or string as it arrives, a closing beat per token with its final kind and
// operator code, and one eof beat per statement. Every input beat that causes
// results marks its final result beat with out_last; beats that cause none
// (spaces, an opening quote, a pending lookahead) give no output at all.
// An input beat is taken every cycle as long as the four-entry result queue
// between the front and back ends has room; the first result of a beat goes
// through the queue and the output register before it is presented. The back
// end hands out one result beat per cycle while out_ready is high, so characters
// that cause two results (a closed token plus a new one, or the &H prefix) use
// two output beats, and the sustained rate is one character per cycle when each
// causes at most one result and out_ready stays high.

module basic_statement_tokenizer import bst_pkg::*; #(
  parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_op_code,
  output logic [7:0]  out_text_byte,
  output logic        out_byte_valid,
  output logic        out_token_done,
  output logic [15:0] out_token_start,
  output logic [7:0]  out_text_length,
  output logic        out_last
);

  logic in_acc;
  logic has_res;
  ent_t entry;
  logic q_full, q_empty, q_pop;
  ent_t q_head;
  res_t res;

  // A character is taken whenever the queue can hold its results.
  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  bst_front #(
    .TEXT_CAPACITY(TEXT_CAPACITY),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .req_type (in_req_type),
    .char_in  (in_char_in),
    .has_res  (has_res),
    .entry    (entry)
  );

  // Only beats that produce results take a queue entry.
  bst_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc && has_res),
    .wdata (entry),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_head)
  );

  bst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_token_kind  = res.token_kind;
  assign out_op_code     = res.op_code;
  assign out_text_byte   = res.text_byte;
  assign out_byte_valid  = res.byte_valid;
  assign out_token_done  = res.token_done;
  assign out_token_start = res.token_start;
  assign out_text_length = res.text_length;

endmodule
